[rtl/swmr_pkg.sv]
// ---------------------------------------------------------------------------
// swmr_pkg: shared types and constants
// Sizes of the sample window and the token that sweeps the cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package swmr_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 7;
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int WIDE_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_W-1:0]       count_t;

  typedef struct packed {
    logic    valid;
    sample_t hi;
    sample_t lo;
    count_t  rem;
  } token_t;

endpackage

`default_nettype wire

[rtl/swmr_cell.sv]
// ---------------------------------------------------------------------------
// swmr_cell: one window position
// Holds one sample, shifts it on to the next cell on an accepted item, and
// folds its sample into the passing max/min token while entries remain.
// ---------------------------------------------------------------------------
`default_nettype none

module swmr_cell
  import swmr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    shift_i,
  input  wire sample_t data_i,
  output sample_t      data_o,
  input  wire token_t  tok_i,
  output token_t       tok_o
);

  sample_t data_q;
  token_t  tok_q, tok_d;
  logic    take;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  always_comb begin
    take  = tok_i.valid && (tok_i.rem != '0);
    tok_d = tok_i;
    if (take) begin
      if (data_q > tok_i.hi) begin
        tok_d.hi = data_q;
      end
      if (data_q < tok_i.lo) begin
        tok_d.lo = data_q;
      end
      tok_d.rem = tok_i.rem - count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid <= 1'b0;
      tok_q.hi    <= '0;
      tok_q.lo    <= '0;
      tok_q.rem   <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign data_o = data_q;
  assign tok_o  = tok_q;

endmodule

`default_nettype wire

[rtl/sliding_window_max_range.sv]
// ---------------------------------------------------------------------------
// sliding_window_max_range: largest window spread over a sample sequence
// Keeps the newest samples in a chain of cells and reports the largest
// window maximum minus minimum once the last sample of a sequence is swept.
// ---------------------------------------------------------------------------
// Each accepted sample shifts into the cell chain, then a max/min token
// walks the chain one cell per cycle, folding in the newest window_size
// entries; the block takes no new sample until the token has left the
// last cell. An item marked last then also loads the result register before
// the next sample is taken, later if the previous result is still waiting.
// The result register lets the next sequence start while a result is held.
// window_size 0 acts as 1 and values above MAX_WINDOW as MAX_WINDOW; a
// sequence shorter than the window reports 0.
`default_nettype none

module sliding_window_max_range
  import swmr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_window_size_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sample_t          sample_i,
  input  wire logic             last_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sample_t               max_spread_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] win_size_q;
  count_t           seen_q;
  sample_t          best_q;
  sample_t          out_q;
  logic             out_valid_q;
  logic             start_q;
  logic             eval_q;
  logic             last_q;

  logic             in_acc;
  logic             fin_load;
  logic [WIDE_W-1:0] ws_wide;
  logic [WIDE_W-1:0] k_wide;
  count_t           win_k;
  count_t           seen_inc;
  sample_t          spread;
  token_t           head_tok;

  sample_t data_w [MAX_WINDOW+1];
  token_t  tok_w  [MAX_WINDOW+1];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign fin_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // effective window length
  always_comb begin
    ws_wide = WIDE_W'(win_size_q);
    if (win_size_q == '0) begin
      k_wide = WIDE_W'(1);
    end else if (ws_wide > WIDE_W'(MAX_WINDOW)) begin
      k_wide = WIDE_W'(MAX_WINDOW);
    end else begin
      k_wide = ws_wide;
    end
    win_k = k_wide[CNT_W-1:0];
  end

  assign seen_inc = (seen_q < count_t'(MAX_WINDOW)) ? seen_q + count_t'(1) : seen_q;

  always_comb begin
    head_tok.valid = start_q;
    head_tok.hi    = '0;
    head_tok.lo    = '1;
    head_tok.rem   = win_k;
  end

  assign data_w[0] = sample_i;
  assign tok_w[0]  = head_tok;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    swmr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .data_i  (data_w[g]),
      .data_o  (data_w[g+1]),
      .tok_i   (tok_w[g]),
      .tok_o   (tok_w[g+1])
    );
  end

  assign spread = tok_w[MAX_WINDOW].hi - tok_w[MAX_WINDOW].lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_size_q  <= CFG_W'(1);
      seen_q      <= '0;
      best_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
      eval_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        win_size_q <= cfg_window_size_i;
      end
      out_valid_q <= fin_load || (out_valid_q && !out_ready_i);
      start_q     <= in_acc;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            seen_q  <= seen_inc;
            eval_q  <= (seen_inc >= win_k);
            last_q  <= last_i;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tok_w[MAX_WINDOW].valid) begin
            if (eval_q && (spread > best_q)) begin
              best_q <= spread;
            end
            state_q <= last_q ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            out_q   <= best_q;
            best_q  <= '0;
            seen_q  <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign max_spread_o = out_q;

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: sliding_window_max_range
// Drives sample sequences through the block under random flow control,
// predicts the largest window spread of each sequence and compares every
// result item with it. A short directed table covers the extremes and the
// window size corner cases, then random sequences run in three idling phases.
// ---------------------------------------------------------------------------
module testbench;
  import swmr_pkg::*;

  localparam int DIR_ROWS     = 23;
  localparam int DRAIN_CYCLES = MAX_WINDOW + 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CFG_W-1:0] wsize;
    sample_t          sample;
    logic             last;
    logic             known;
    sample_t          spread;
  } stim_row_t;

  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             cfg_valid_i       = 1'b0;
  logic [CFG_W-1:0] cfg_window_size_i = '0;
  logic             in_valid_i        = 1'b0;
  sample_t          sample_i          = '0;
  logic             last_i            = 1'b0;
  logic             out_ready_i       = 1'b0;
  logic             cfg_ready_o;
  logic             in_ready_o;
  logic             out_valid_o;
  sample_t          max_spread_o;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 50;
  int unsigned items_sent    = 0;
  int unsigned fail_count    = 0;

  // predictor state
  logic [CFG_W-1:0] window_cfg = 7'd1;
  sample_t          recent [MAX_WINDOW];
  int unsigned      seq_seen = 0;
  sample_t          seq_best = '0;
  sample_t          spread_q [$];

  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM, 7'd0,   16'h1234, 1'b1, 1'b1, 16'h0000},
    '{ROW_CFG,  7'd2,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
    '{ROW_ITEM, 7'd0,   16'h5555, 1'b1, 1'b1, 16'h0000},
    '{ROW_CFG,  7'd0,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'h0000, 1'b1, 1'b1, 16'h0000},
    '{ROW_CFG,  7'd127, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'hAAAA, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'h5555, 1'b1, 1'b1, 16'h0000},
    '{ROW_CFG,  7'd65,  16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'hFFFF, 1'b1, 1'b1, 16'h0000},
    '{ROW_CFG,  7'd3,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'h0001, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'h8000, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG,  7'd2,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'h7FFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000},
    '{ROW_CFG,  7'd64,  16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG,  7'd1,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 7'd0,   16'hFFFF, 1'b1, 1'b1, 16'h0000}
  };

  sliding_window_max_range dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_window_size_i(cfg_window_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .max_spread_o     (max_spread_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned window_len(input logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WINDOW) return MAX_WINDOW;
    return w;
  endfunction

  function automatic void fold_sample(input sample_t s, input logic l,
                                      output bit got, output sample_t spread);
    int unsigned k;
    sample_t hi;
    sample_t lo;
    k = window_len(window_cfg);
    for (int i = MAX_WINDOW - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = s;
    if (seq_seen < MAX_WINDOW) seq_seen++;
    if (seq_seen >= k) begin
      hi = recent[0];
      lo = recent[0];
      for (int i = 1; i < k; i++) begin
        if (recent[i] > hi) hi = recent[i];
        if (recent[i] < lo) lo = recent[i];
      end
      if (hi - lo > seq_best) seq_best = hi - lo;
    end
    got = l;
    spread = seq_best;
    if (l) begin
      seq_seen = 0;
      seq_best = '0;
    end
  endfunction

  function automatic void flag_error(input string msg);
    if (fail_count < 10) $display("ERROR: %s", msg);
    fail_count++;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (spread_q.size() == 0) begin
        flag_error($sformatf("unexpected result item max_spread=%h", max_spread_o));
      end else begin
        want = spread_q.pop_front();
        if (max_spread_o !== want)
          flag_error($sformatf("max_spread expected %h got %h", want, max_spread_o));
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_sample(input sample_t s, input logic l, input bit known,
                             input sample_t typed);
    bit got;
    sample_t spread;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    fold_sample(s, l, got, spread);
    if (got) spread_q = {spread_q, (known ? typed : spread)};
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    in_valid_i <= 1'b0;
    while (spread_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_window_size_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    window_cfg = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned r;
    int unsigned k;
    int unsigned len;
    int unsigned nseq;
    logic [CFG_W-1:0] w;
    sample_t base;
    sample_t smp;
    bit keep_open;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 5) w = 7'd0;
      else if (r < 10) w = 7'd64;
      else if (r < 15) w = CFG_W'($urandom_range(65, 127));
      else if (r < 20) w = 7'd1;
      else if (r < 30) w = CFG_W'($urandom_range(9, 63));
      else w = CFG_W'($urandom_range(2, 8));
      write_window(w);
      k = window_len(w);
      nseq = $urandom_range(1, 3);
      for (int q = 0; q < nseq; q++) begin
        r = $urandom_range(99);
        if (r < 10) len = $urandom_range(1, k);
        else if (r < 18) len = $urandom_range(1, 80);
        else len = $urandom_range(k, k + 12);
        base = sample_t'($urandom);
        // an open tail carries the sequence across the next window change
        keep_open = (q == nseq - 1) && ($urandom_range(99) < 20);
        for (int j = 0; j < len; j++) begin
          r = $urandom_range(99);
          if (r < 15) smp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          else if (r < 55) smp = sample_t'($urandom);
          else smp = base + sample_t'($urandom_range(255));
          push_sample(smp, (j == len - 1) && !keep_open, 1'b0, '0);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_window(dir_tab[i].wsize);
      else
        push_sample(dir_tab[i].sample, dir_tab[i].last, dir_tab[i].known,
                    dir_tab[i].spread);
    end

    run_random(380);
    send_idle_pct = 50;
    recv_idle_pct = 34;
    run_random(740);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(1100);
    push_sample(sample_t'($urandom), 1'b1, 1'b0, '0);

    in_valid_i <= 1'b0;
    while (spread_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
